### rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// The expression must hold at every clock edge outside reset.
`define CHK_ALWAYS(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

### rtl/hsbf_pkg.sv
// Package for the hash slice Bloom filter: sizes, command codes, register
// indexes, state encoding and the control/status bundles between modules.
// Depends on nothing.
package hsbf_pkg;

  localparam int LOG2_MAX_FILTER_BITS = 24;
  localparam int HASH_BITS = 192;

  localparam int WORD_W = 64;
  localparam int SLICE_W = 64;
  localparam int HC_W = 8;
  localparam int BPH_W = 7;
  localparam int FSB_W = 25;
  localparam int CMD_W = 2;
  localparam int LOAD_IDX_W = 21;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 25;

  localparam int ADDR_W = LOG2_MAX_FILTER_BITS - 3;
  localparam int STORE_BYTES = 1 << ADDR_W;
  localparam int STORE_BITS = 1 << LOG2_MAX_FILTER_BITS;
  localparam int REM_W = LOG2_MAX_FILTER_BITS;
  localparam int SIZE_W = LOG2_MAX_FILTER_BITS + 1;
  localparam int RADIX_BITS = 4;
  localparam int TAKE_W = $clog2(SLICE_W + 1);
  localparam int STEP_W = $clog2(SLICE_W / RADIX_BITS + 1);
  localparam int POS_W = $clog2(HASH_BITS + 1);
  localparam int END_W = ((POS_W > BPH_W) ? POS_W : BPH_W) + 1;

  typedef logic [3*WORD_W-1:0]  hash_t;
  typedef logic [SLICE_W-1:0]   slice_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [REM_W-1:0]     bitidx_t;
  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [TAKE_W-1:0]    take_t;
  typedef logic [STEP_W-1:0]    step_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [END_W-1:0]     end_t;
  typedef logic [HC_W-1:0]      count_t;
  typedef logic [BPH_W-1:0]     bph_t;
  typedef logic [FSB_W-1:0]     fsb_t;

  localparam count_t HASH_COUNT_RST = count_t'(1);
  localparam bph_t   BPH_RST = bph_t'(24);
  localparam fsb_t   FSB_RST = fsb_t'(0);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_TEST = 2'd1,
    CMD_LOAD = 2'd2
  } cmd_code_t;

  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_HASH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE   = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_SLICE,
    S_DIV,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic ready;
    logic capture;
    logic clear_en;
    logic load_wr;
    logic div_start;
    logic advance;
    logic set_bit;
    logic hit_clear;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic new_load;
    logic new_walk;
    logic div_done;
    logic is_test;
    logic bit_hit;
    logic more;
    logic hit;
  } dp_status_t;

endpackage

### rtl/hsbf_rem_unit.sv
// Iterative remainder unit: slice value modulo the filter size, four
// quotient bits per cycle. Depends on hsbf_pkg.
module hsbf_rem_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  hsbf_pkg::slice_t dividend,
  input  hsbf_pkg::step_t  steps,
  input  hsbf_pkg::size_t  divisor,
  output logic             done,
  output hsbf_pkg::bitidx_t rem
);

  hsbf_pkg::slice_t  sh;
  hsbf_pkg::step_t   cnt;
  hsbf_pkg::bitidx_t rem_next;

  // Restoring division, one radix-16 digit per cycle. The remainder stays
  // below the divisor, so it never needs more than REM_W bits.
  always_comb begin
    hsbf_pkg::size_t t;
    hsbf_pkg::bitidx_t r_work;
    r_work = rem;
    for (int j = 0; j < hsbf_pkg::RADIX_BITS; j++) begin
      t = {r_work, sh[hsbf_pkg::SLICE_W-1-j]};
      if (t >= divisor) begin
        t = t - divisor;
      end
      r_work = t[hsbf_pkg::REM_W-1:0];
    end
    rem_next = r_work;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // The slice is left aligned so that only its significant digits are fed.
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend << (hsbf_pkg::SLICE_W - hsbf_pkg::RADIX_BITS * int'(steps));
      rem <= '0;
    end else if (cnt != '0) begin
      sh  <= sh << hsbf_pkg::RADIX_BITS;
      rem <= rem_next;
    end
  end

  assign done = (cnt == '0);

endmodule

### rtl/hsbf_datapath.sv
// Datapath of the Bloom filter: captured word, slice extraction, the
// remainder unit and the byte-wide filter store. Depends on hsbf_pkg.
module hsbf_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  hsbf_pkg::ctrl_cmd_t                cmd,
  output hsbf_pkg::dp_status_t               status,
  input  logic [hsbf_pkg::CMD_W-1:0]         command,
  input  logic [hsbf_pkg::WORD_W-1:0]        hash_low,
  input  logic [hsbf_pkg::WORD_W-1:0]        hash_mid,
  input  logic [hsbf_pkg::WORD_W-1:0]        hash_high,
  input  logic [hsbf_pkg::LOAD_IDX_W-1:0]    load_byte_index,
  input  logic [7:0]                         load_byte,
  input  hsbf_pkg::count_t                   hash_count,
  input  hsbf_pkg::bph_t                     bits_per_hash,
  input  hsbf_pkg::fsb_t                     filter_size_bits
);

  logic [7:0] store_mem [hsbf_pkg::STORE_BYTES];

  logic [hsbf_pkg::CMD_W-1:0]      cmd_q;
  hsbf_pkg::hash_t                 hash_q;
  logic [hsbf_pkg::LOAD_IDX_W-1:0] load_idx_q;
  logic [7:0]                      load_byte_q;
  logic                            hit_q;
  logic                            last_q;
  hsbf_pkg::pos_t                  start_pos;
  hsbf_pkg::count_t                n;
  hsbf_pkg::addr_t                 clear_addr;

  hsbf_pkg::size_t   size_eff;
  logic              size_zero;
  hsbf_pkg::hash_t   shifted;
  hsbf_pkg::take_t   take;
  hsbf_pkg::slice_t  mask;
  hsbf_pkg::end_t    slice_end;
  logic              slice_bad;
  hsbf_pkg::slice_t  slice_val;
  hsbf_pkg::step_t   slice_steps;
  logic              div_done;
  hsbf_pkg::bitidx_t rem;
  logic [hsbf_pkg::HC_W:0] n_plus;

  logic            mem_we;
  hsbf_pkg::addr_t mem_waddr;
  logic [7:0]      mem_wdata;
  hsbf_pkg::addr_t mem_raddr;
  logic [7:0]      mem_rdata;
  logic [7:0]      bit_mask;
  logic            load_ok;

  // A size above the store is treated as the whole store.
  always_comb begin
    if (filter_size_bits > hsbf_pkg::fsb_t'(hsbf_pkg::STORE_BITS)) begin
      size_eff = hsbf_pkg::size_t'(hsbf_pkg::STORE_BITS);
    end else begin
      size_eff = hsbf_pkg::size_t'(filter_size_bits);
    end
  end
  assign size_zero = (size_eff == '0);

  // Slice n covers bits start_pos and up; once it runs past the end of the
  // hash the index is zero, and the walk stops after that slice.
  always_comb begin
    shifted = hash_q >> start_pos;
    if (bits_per_hash > hsbf_pkg::bph_t'(hsbf_pkg::SLICE_W)) begin
      take = hsbf_pkg::take_t'(hsbf_pkg::SLICE_W);
    end else begin
      take = hsbf_pkg::take_t'(bits_per_hash);
    end
    mask = ~({hsbf_pkg::SLICE_W{1'b1}} << take);
    slice_end = hsbf_pkg::end_t'(start_pos) + hsbf_pkg::end_t'(bits_per_hash);
    slice_bad = (slice_end > hsbf_pkg::end_t'(hsbf_pkg::HASH_BITS));
    if (slice_bad) begin
      slice_val   = '0;
      slice_steps = '0;
    end else begin
      slice_val   = shifted[hsbf_pkg::SLICE_W-1:0] & mask;
      slice_steps = hsbf_pkg::step_t'((int'(take) + hsbf_pkg::RADIX_BITS - 1)
                                      / hsbf_pkg::RADIX_BITS);
    end
  end

  hsbf_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (slice_val),
    .steps    (slice_steps),
    .divisor  (size_eff),
    .done     (div_done),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_en) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q       <= command;
      hash_q      <= {hash_high, hash_mid, hash_low};
      load_idx_q  <= load_byte_index;
      load_byte_q <= load_byte;
      hit_q       <= (command == hsbf_pkg::CMD_TEST) && !size_zero;
      start_pos   <= '0;
      n           <= '0;
    end else begin
      if (cmd.advance) begin
        start_pos <= hsbf_pkg::pos_t'(slice_end);
        n         <= n + 1'b1;
      end
      if (cmd.hit_clear) begin
        hit_q <= 1'b0;
      end
    end
    if (cmd.div_start) begin
      last_q <= slice_bad;
    end
  end

  // One write port shared by the clearing sweep, byte loads and bit sets.
  always_comb begin
    load_ok   = (int'(load_idx_q) < hsbf_pkg::STORE_BYTES);
    bit_mask  = 8'b1 << rem[2:0];
    mem_raddr = rem[hsbf_pkg::REM_W-1:3];
    mem_we    = 1'b0;
    mem_waddr = clear_addr;
    mem_wdata = '0;
    if (cmd.clear_en) begin
      mem_we = 1'b1;
    end else if (cmd.load_wr) begin
      mem_we    = load_ok;
      mem_waddr = hsbf_pkg::addr_t'(load_idx_q);
      mem_wdata = load_byte_q;
    end else if (cmd.set_bit) begin
      mem_we    = 1'b1;
      mem_waddr = mem_raddr;
      mem_wdata = mem_rdata | bit_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= store_mem[mem_raddr];
  end

  assign n_plus = {1'b0, n} + 1'b1;

  always_comb begin
    status            = '0;
    status.clear_last = (clear_addr == {hsbf_pkg::ADDR_W{1'b1}});
    status.new_load   = (command == hsbf_pkg::CMD_LOAD);
    status.new_walk   = (command inside {hsbf_pkg::CMD_ADD, hsbf_pkg::CMD_TEST})
                        && !size_zero && (hash_count != '0);
    status.div_done   = div_done;
    status.is_test    = (cmd_q == hsbf_pkg::CMD_TEST);
    status.bit_hit    = mem_rdata[rem[2:0]];
    status.more       = !last_q && (n_plus < {1'b0, hash_count});
    status.hit        = hit_q;
  end

endmodule

### rtl/hsbf_ctrl.sv
// Controller state machine of the Bloom filter: store clearing, command
// dispatch and the walk over the hash indices. Depends on hsbf_pkg.
module hsbf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  hsbf_pkg::dp_status_t status,
  output hsbf_pkg::ctrl_cmd_t  cmd
);

  hsbf_pkg::state_t state;
  hsbf_pkg::state_t state_next;
  logic             miss;

  assign miss = status.is_test && !status.bit_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsbf_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hsbf_pkg::S_CLEAR: begin
        if (status.clear_last) begin
          state_next = hsbf_pkg::S_IDLE;
        end
      end
      hsbf_pkg::S_IDLE: begin
        if (in_valid) begin
          if (status.new_load) begin
            state_next = hsbf_pkg::S_LOAD;
          end else if (status.new_walk) begin
            state_next = hsbf_pkg::S_SLICE;
          end else begin
            state_next = hsbf_pkg::S_DONE;
          end
        end
      end
      hsbf_pkg::S_LOAD: state_next = hsbf_pkg::S_DONE;
      hsbf_pkg::S_SLICE: state_next = hsbf_pkg::S_DIV;
      hsbf_pkg::S_DIV: begin
        if (status.div_done) begin
          state_next = hsbf_pkg::S_CHECK;
        end
      end
      hsbf_pkg::S_CHECK: begin
        // A test stops at its first clear bit.
        if (!miss && status.more) begin
          state_next = hsbf_pkg::S_SLICE;
        end else begin
          state_next = hsbf_pkg::S_DONE;
        end
      end
      hsbf_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = hsbf_pkg::S_IDLE;
        end
      end
      default: state_next = hsbf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      hsbf_pkg::S_CLEAR: cmd.clear_en = 1'b1;
      hsbf_pkg::S_IDLE: begin
        cmd.ready   = 1'b1;
        cmd.capture = in_valid;
      end
      hsbf_pkg::S_LOAD: cmd.load_wr = 1'b1;
      hsbf_pkg::S_SLICE: cmd.div_start = 1'b1;
      hsbf_pkg::S_DIV: cmd = '0;
      hsbf_pkg::S_CHECK: begin
        cmd.set_bit   = !status.is_test;
        cmd.hit_clear = miss;
        cmd.advance   = !miss && status.more;
      end
      hsbf_pkg::S_DONE: cmd.out_load = !out_valid || !out_stall;
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/hash_slice_bloom_filter_core.sv
// Bloom filter over 192-bit hashes with a 16M-bit store, one word at a time.
// After reset the store is swept to zero, one byte per cycle; input is
// stalled during the sweep, though configuration writes are taken. A load
// word is captured, written to the store, and its result is then loaded.
// An add or test word is captured and then, for every hash index visited,
// its slice is reduced modulo the filter size by the radix-16 remainder
// unit and the bit is set or checked through the single read/modify/write
// port of the byte store.
// A test stops at its first clear bit, and the walk stops at the first slice
// that runs past the end of the hash. A finished result waits in the output
// register while the next word is accepted.
`include "assert_macros.svh"

module hash_slice_bloom_filter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [hsbf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hsbf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hsbf_pkg::CMD_W-1:0]          command,
  input  logic [hsbf_pkg::WORD_W-1:0]         hash_low,
  input  logic [hsbf_pkg::WORD_W-1:0]         hash_mid,
  input  logic [hsbf_pkg::WORD_W-1:0]         hash_high,
  input  logic [hsbf_pkg::LOAD_IDX_W-1:0]     load_byte_index,
  input  logic [7:0]                          load_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                hit
);

  hsbf_pkg::count_t     hash_count;
  hsbf_pkg::bph_t       bits_per_hash;
  hsbf_pkg::fsb_t       filter_size_bits;
  hsbf_pkg::ctrl_cmd_t  ctrl_cmd;
  hsbf_pkg::dp_status_t dp_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_count       <= hsbf_pkg::HASH_COUNT_RST;
      bits_per_hash    <= hsbf_pkg::BPH_RST;
      filter_size_bits <= hsbf_pkg::FSB_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hsbf_pkg::REG_HASH_COUNT:    hash_count <= cfg_data[hsbf_pkg::HC_W-1:0];
        hsbf_pkg::REG_BITS_PER_HASH: bits_per_hash <= cfg_data[hsbf_pkg::BPH_W-1:0];
        hsbf_pkg::REG_FILTER_SIZE:   filter_size_bits <= cfg_data[hsbf_pkg::FSB_W-1:0];
        default: hash_count <= hash_count;
      endcase
    end
  end

  hsbf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (dp_status),
    .cmd       (ctrl_cmd)
  );

  hsbf_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (ctrl_cmd),
    .status           (dp_status),
    .command          (command),
    .hash_low         (hash_low),
    .hash_mid         (hash_mid),
    .hash_high        (hash_high),
    .load_byte_index  (load_byte_index),
    .load_byte        (load_byte),
    .hash_count       (hash_count),
    .bits_per_hash    (bits_per_hash),
    .filter_size_bits (filter_size_bits)
  );

  assign in_stall = !ctrl_cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl_cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.out_load) begin
      hit <= dp_status.hit;
    end
  end

  `CHK_IMPLY(a_out_free, clk, rst, ctrl_cmd.out_load, !out_valid || !out_stall, "result overwritten before it was taken")
  `CHK_ALWAYS(a_one_writer, clk, rst, $onehot0({ctrl_cmd.clear_en, ctrl_cmd.load_wr, ctrl_cmd.set_bit}), "two writers on the store port")
  `CHK_IMPLY(a_div_idle, clk, rst, ctrl_cmd.div_start, dp_status.div_done, "remainder unit restarted while busy")
  `CHK_IMPLY(a_no_word_in_clear, clk, rst, ctrl_cmd.clear_en, in_stall, "word accepted during the clearing sweep")

endmodule
